// ===== design/slr_pkg.sv =====
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types and constants for the sound lump resampler.
// ----------------------------------------------------------------------------
package slr_pkg;

    // Divider operand width: count (32 bits) times mixer rate (18 bits)
    localparam int DIV_W  = 50;
    localparam int STEP_W = 40;
    localparam int CNT_W  = 32;
    localparam int RATE_W = 16;
    localparam int MIX_W  = 18;

    localparam logic [7:0]        HDR_FMT_LO     = 8'h03;
    localparam logic [7:0]        HDR_FMT_HI     = 8'h00;
    localparam logic [31:0]       HDR_LEN        = 32'd8;
    localparam logic [15:0]       SAMPLE_BIAS    = 16'h8000;
    localparam logic [MIX_W-1:0]  MIXER_RATE_RST = 18'd44100;

    // Register index, taken from paddr[2]
    localparam logic REG_MIXER_RATE = 1'b0;
    localparam logic REG_LUMP_BYTES = 1'b1;

    localparam logic [1:0] STAT_SAMPLE  = 2'd0;
    localparam logic [1:0] STAT_BAD_HDR = 2'd1;
    localparam logic [1:0] STAT_RATIO   = 2'd2;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_STREAM = 2'd1,
        MODE_IDLE   = 2'd2
    } mode_t;

    typedef enum logic [7:0] {
        ST_WAIT  = 8'b00000001,
        ST_CHECK = 8'b00000010,
        ST_DIV1  = 8'b00000100,
        ST_TOT   = 8'b00001000,
        ST_DIV2  = 8'b00010000,
        ST_RAT   = 8'b00100000,
        ST_EMIT  = 8'b01000000,
        ST_ERR   = 8'b10000000
    } state_t;

endpackage

// ===== design/sound_lump_resampler.sv =====
// ----------------------------------------------------------------------------
// sound_lump_resampler
// Parses a sound lump header and converts 8-bit unsigned samples to stereo
// signed 16-bit samples at the mixer rate by nearest-neighbor selection.
// ----------------------------------------------------------------------------
// Sequence: an accepted header byte 7 is followed by the header checks, then
//   two passes through the shared divider, one for the output total and one
//   for the step.
// Throughput: a sample byte is not accepted before all its outputs are sent,
//   one output per cycle while the output side takes them.
// Reset: mixer_rate = 44100, lump_bytes = 0, parser waits for header byte 0.
// ----------------------------------------------------------------------------
module sound_lump_resampler #(
    parameter int unsigned MAX_OUT_PER_BYTE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] first_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic [2:0]  m_tuser,   // [1:0] status, [2] sound_end
    output logic        m_tlast    // run_last
);
    import slr_pkg::*;

    localparam int N_W      = $clog2(MAX_OUT_PER_BYTE + 1);
    localparam int STEP_MIN = (256 + MAX_OUT_PER_BYTE - 1) / MAX_OUT_PER_BYTE;

    // configuration registers
    logic [MIX_W-1:0] mixer_rate_reg;
    logic [31:0]      lump_bytes_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mixer_rate_reg <= MIXER_RATE_RST;
            lump_bytes_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_MIXER_RATE)
                mixer_rate_reg <= pwdata[MIX_W-1:0];
            else
                lump_bytes_reg <= pwdata;
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_LUMP_BYTES)
            prdata = lump_bytes_reg;
        else
            prdata = {{(32-MIX_W){1'b0}}, mixer_rate_reg};
    end

    // control and datapath state
    state_t              state_reg,   state_next;
    mode_t               mode_reg,    mode_next;
    logic [2:0]          pos_reg,     pos_next;
    logic [RATE_W-1:0]   rate_reg,    rate_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [CNT_W-1:0]    sidx_reg,    sidx_next;
    logic [DIV_W-1:0]    oidx_reg,    oidx_next;
    logic [DIV_W-1:0]    total_reg,   total_next;
    logic [STEP_W-1:0]   step_reg,    step_next;
    logic [STEP_W-1:0]   acc_reg,     acc_next;
    logic [N_W-1:0]      n_reg,       n_next;
    logic [7:0]          byte_reg,    byte_next;
    logic [1:0]          err_reg,     err_next;

    // output register
    logic                ov_reg,      ov_next;
    logic [15:0]         osmp_reg,    osmp_next;
    logic [1:0]          ostat_reg,   ostat_next;
    logic                olast_reg,   olast_next;
    logic                oend_reg,    oend_next;

    // shared divider
    logic                div_start;
    logic [DIV_W-1:0]    div_numer;
    logic [DIV_W-1:0]    div_denom;
    logic                div_done;
    logic [DIV_W-1:0]    div_quot;

    slr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .done  (div_done),
        .quot  (div_quot)
    );

    // helpers
    mode_t               mode_eff;
    logic [2:0]          pos_eff;
    logic [7:0]          in_byte;
    logic                out_free;
    logic [DIV_W-1:0]    product;
    logic [31:0]         lump_m8;
    logic                hdr_bad;
    logic [STEP_W-1:0]   acc_sum;
    logic [DIV_W-1:0]    oidx_inc;
    logic [N_W-1:0]      n_inc;
    logic                emit_now;
    logic                emit_more;
    logic                src_done;
    logic [15:0]         widened;

    assign in_byte   = s_tdata;
    assign out_free  = !ov_reg || m_tready;
    assign product   = DIV_W'(count_reg) * DIV_W'(mixer_rate_reg);
    assign lump_m8   = lump_bytes_reg - HDR_LEN;
    assign hdr_bad   = (lump_bytes_reg < HDR_LEN) || (count_reg > lump_m8)
                       || (rate_reg == '0);
    assign acc_sum   = acc_reg + step_reg;
    assign oidx_inc  = oidx_reg + 1'b1;
    assign n_inc     = n_reg + 1'b1;
    assign emit_now  = (n_reg < N_W'(MAX_OUT_PER_BYTE)) && (oidx_reg < total_reg)
                       && (acc_reg[STEP_W-1:8] == sidx_reg);
    assign emit_more = (n_inc < N_W'(MAX_OUT_PER_BYTE)) && (oidx_inc < total_reg)
                       && (acc_sum[STEP_W-1:8] == sidx_reg);
    assign src_done  = ({1'b0, sidx_reg} + 33'd1) >= {1'b0, count_reg};
    assign widened   = {byte_reg, byte_reg} ^ SAMPLE_BIAS;

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        rate_next  = rate_reg;
        count_next = count_reg;
        sidx_next  = sidx_reg;
        oidx_next  = oidx_reg;
        total_next = total_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        n_next     = n_reg;
        byte_next  = byte_reg;
        err_next   = err_reg;
        ov_next    = ov_reg && !m_tready;
        osmp_next  = osmp_reg;
        ostat_next = ostat_reg;
        olast_next = olast_reg;
        oend_next  = oend_reg;
        div_start  = 1'b0;
        div_numer  = product;
        div_denom  = DIV_W'(rate_reg);
        mode_eff   = s_tuser[0] ? MODE_HEADER : mode_reg;
        pos_eff    = s_tuser[0] ? 3'd0 : pos_reg;
        s_tready   = (state_reg == ST_WAIT);

        case (state_reg)
            ST_WAIT:
            begin
                if (s_tvalid)
                begin
                    mode_next = mode_eff;
                    pos_next  = pos_eff;
                    case (mode_eff)
                        MODE_HEADER:
                        begin
                            pos_next = pos_eff + 1'b1;
                            case (pos_eff)
                                3'd0:
                                begin
                                    if (lump_bytes_reg < HDR_LEN || in_byte != HDR_FMT_LO)
                                    begin
                                        err_next   = STAT_BAD_HDR;
                                        mode_next  = MODE_IDLE;
                                        state_next = ST_ERR;
                                    end
                                end
                                3'd1:
                                begin
                                    if (in_byte != HDR_FMT_HI)
                                    begin
                                        err_next   = STAT_BAD_HDR;
                                        mode_next  = MODE_IDLE;
                                        state_next = ST_ERR;
                                    end
                                end
                                3'd2: rate_next[7:0]    = in_byte;
                                3'd3: rate_next[15:8]   = in_byte;
                                3'd4: count_next[7:0]   = in_byte;
                                3'd5: count_next[15:8]  = in_byte;
                                3'd6: count_next[23:16] = in_byte;
                                3'd7:
                                begin
                                    count_next[31:24] = in_byte;
                                    state_next        = ST_CHECK;
                                end
                                default: pos_next = pos_eff;
                            endcase
                        end
                        MODE_STREAM:
                        begin
                            byte_next  = in_byte;
                            n_next     = '0;
                            state_next = ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (hdr_bad)
                begin
                    err_next   = STAT_BAD_HDR;
                    mode_next  = MODE_IDLE;
                    state_next = ST_ERR;
                end
                else
                begin
                    // out_total = count * mixer_rate / rate
                    div_start  = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    total_next = div_quot;
                    state_next = ST_TOT;
                end
            end
            ST_TOT:
            begin
                if (total_reg == '0)
                begin
                    mode_next  = MODE_IDLE;
                    state_next = ST_WAIT;
                end
                else
                begin
                    // step = (count << 8) / out_total
                    div_start  = 1'b1;
                    div_numer  = DIV_W'({count_reg, 8'h00});
                    div_denom  = total_reg;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    step_next  = div_quot[STEP_W-1:0];
                    state_next = ST_RAT;
                end
            end
            ST_RAT:
            begin
                if (step_reg < STEP_W'(STEP_MIN))
                begin
                    err_next   = STAT_RATIO;
                    mode_next  = MODE_IDLE;
                    state_next = ST_ERR;
                end
                else
                begin
                    sidx_next  = '0;
                    oidx_next  = '0;
                    acc_next   = '0;
                    mode_next  = MODE_STREAM;
                    state_next = ST_WAIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_now)
                begin
                    if (out_free)
                    begin
                        ov_next    = 1'b1;
                        osmp_next  = widened;
                        ostat_next = STAT_SAMPLE;
                        olast_next = !emit_more;
                        oend_next  = (oidx_inc == total_reg);
                        oidx_next  = oidx_inc;
                        acc_next   = acc_sum;
                        n_next     = n_inc;
                        if (!emit_more)
                        begin
                            sidx_next  = sidx_reg + 1'b1;
                            state_next = ST_WAIT;
                            if (src_done || oidx_inc >= total_reg)
                                mode_next = MODE_IDLE;
                        end
                    end
                end
                else
                begin
                    // byte selects no output
                    sidx_next  = sidx_reg + 1'b1;
                    state_next = ST_WAIT;
                    if (src_done || oidx_reg >= total_reg)
                        mode_next = MODE_IDLE;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    osmp_next  = '0;
                    ostat_next = err_reg;
                    olast_next = 1'b1;
                    oend_next  = 1'b0;
                    state_next = ST_WAIT;
                end
            end
            default: state_next = ST_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
            mode_reg  <= MODE_HEADER;
            pos_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg  <= rate_next;
        count_reg <= count_next;
        sidx_reg  <= sidx_next;
        oidx_reg  <= oidx_next;
        total_reg <= total_next;
        step_reg  <= step_next;
        acc_reg   <= acc_next;
        n_reg     <= n_next;
        byte_reg  <= byte_next;
        err_reg   <= err_next;
        osmp_reg  <= osmp_next;
        ostat_reg <= ostat_next;
        olast_reg <= olast_next;
        oend_reg  <= oend_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {osmp_reg, osmp_reg};
    assign m_tuser  = {oend_reg, ostat_reg};
    assign m_tlast  = olast_reg;

endmodule

// ===== design/slr_div.sv =====
// ----------------------------------------------------------------------------
// slr_div
// Restoring divider, one quotient bit per cycle; a start while busy restarts it.
// ----------------------------------------------------------------------------
module slr_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [slr_pkg::DIV_W-1:0] numer,
    input  logic [slr_pkg::DIV_W-1:0] denom,
    output logic                      done,
    output logic [slr_pkg::DIV_W-1:0] quot
);
    import slr_pkg::*;

    localparam int ITER_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  quot_reg,  quot_next;
    logic [DIV_W-1:0]  rem_reg,   rem_next;
    logic [DIV_W-1:0]  den_reg,   den_next;
    logic [ITER_W-1:0] iter_reg,  iter_next;
    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, quot_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
            iter_next = ITER_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one numerator bit, subtract when the divisor fits
            rem_next  = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quot_next = {quot_reg[DIV_W-2:0], fits};
            iter_next = iter_reg - 1'b1;
            if (iter_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
